### rtl/hsv2rgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Port widths fixed by the pixel format
  localparam int HUE_W = 9;
  localparam int SV_W  = 13;
  localparam int CH_W  = 8;

  localparam int FRAC_BITS_DEF = 12;

  // Hue arithmetic
  localparam int HM_W = 7;   // hue mod 120
  localparam int K_W  = 6;   // secondary weight, 0..60
  localparam logic [HUE_W-1:0] HUE_SEXT_DEG = HUE_W'(60);

  // Secondary channel: T / 60 done as (T >> 2) / 15 by reciprocal
  localparam int T_W  = 14;
  localparam int U_W  = 12;
  localparam int Q_W  = 9;
  localparam int RCP_W = 13;
  localparam logic [RCP_W-1:0] DIV15_RCP = RCP_W'(4369);
  localparam int DIV15_SHIFT = 16;
  localparam logic [U_W:0] DIV15_N = (U_W + 1)'(15);

  typedef enum logic [2:0] {
    SEXT_0,
    SEXT_1,
    SEXT_2,
    SEXT_3,
    SEXT_4,
    SEXT_5UP
  } sextant_e;

  // Per-stage load enables, handed from the pipeline control
  typedef struct packed {
    logic hue;
    logic mul;
    logic sub;
    logic sum;
    logic scale;
    logic recip;
    logic out;
  } stage_en_t;

  function automatic logic [CH_W-1:0] sat_chan(input logic [Q_W-1:0] val);
    logic [CH_W-1:0] res;
    res = (val > Q_W'({CH_W{1'b1}})) ? {CH_W{1'b1}} : val[CH_W-1:0];
    return res;
  endfunction

endpackage

### rtl/hsv2rgb_hue.sv
// First stage: hue decode (sextant and secondary weight) and clamping of S and V.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_hue #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  hsv2rgb_pkg::stage_en_t        en_i,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_i,
  input  logic [hsv2rgb_pkg::SV_W-1:0]  saturation_i,
  input  logic [hsv2rgb_pkg::SV_W-1:0]  brightness_i,
  output logic [FRAC_BITS:0]            s_o,
  output logic [FRAC_BITS:0]            v_o,
  output logic [hsv2rgb_pkg::K_W-1:0]   k_o,
  output hsv2rgb_pkg::sextant_e         sext_o
);
  import hsv2rgb_pkg::*;

  localparam int VW    = FRAC_BITS + 1;
  localparam int CMP_W = (VW > SV_W) ? VW : SV_W;

  logic [CMP_W-1:0] one, s_ext, v_ext, s_cl, v_cl;
  logic [HUE_W-1:0] hm_full;
  logic [HM_W-1:0]  hm;
  logic [K_W-1:0]   hue_dist;

  logic [VW-1:0]  s_d, s_q, v_d, v_q;
  logic [K_W-1:0] k_d, k_q;
  sextant_e       sext_d, sext_q;

  always_comb begin
    one   = CMP_W'(1) << FRAC_BITS;
    s_ext = CMP_W'(saturation_i);
    v_ext = CMP_W'(brightness_i);
    s_cl  = (s_ext > one) ? one : s_ext;
    v_cl  = (v_ext > one) ? one : v_ext;
    s_d   = s_cl[VW-1:0];
    v_d   = v_cl[VW-1:0];

    // hue mod 120 by range
    if (hue_i < 2 * HUE_SEXT_DEG) begin
      hm_full = hue_i;
    end else if (hue_i < 4 * HUE_SEXT_DEG) begin
      hm_full = HUE_W'(hue_i - 2 * HUE_SEXT_DEG);
    end else if (hue_i < 6 * HUE_SEXT_DEG) begin
      hm_full = HUE_W'(hue_i - 4 * HUE_SEXT_DEG);
    end else if (hue_i < 8 * HUE_SEXT_DEG) begin
      hm_full = HUE_W'(hue_i - 6 * HUE_SEXT_DEG);
    end else begin
      hm_full = HUE_W'(hue_i - 8 * HUE_SEXT_DEG);
    end
    hm = hm_full[HM_W-1:0];

    hue_dist = (hm >= HM_W'(HUE_SEXT_DEG)) ? K_W'(hm - HM_W'(HUE_SEXT_DEG))
                                           : K_W'(HM_W'(HUE_SEXT_DEG) - hm);
    k_d  = K_W'(HUE_SEXT_DEG) - hue_dist;

    if (hue_i < HUE_SEXT_DEG) begin
      sext_d = SEXT_0;
    end else if (hue_i < 2 * HUE_SEXT_DEG) begin
      sext_d = SEXT_1;
    end else if (hue_i < 3 * HUE_SEXT_DEG) begin
      sext_d = SEXT_2;
    end else if (hue_i < 4 * HUE_SEXT_DEG) begin
      sext_d = SEXT_3;
    end else if (hue_i < 5 * HUE_SEXT_DEG) begin
      sext_d = SEXT_4;
    end else begin
      sext_d = SEXT_5UP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.hue) begin
      s_q    <= s_d;
      v_q    <= v_d;
      k_q    <= k_d;
      sext_q <= sext_d;
    end
  end

  assign s_o    = s_q;
  assign v_o    = v_q;
  assign k_o    = k_q;
  assign sext_o = sext_q;

endmodule

### rtl/hsv2rgb_arith.sv
// Stages two to four: chroma c = v*s, offset m = v - c, weighted sum c*k + 60*m.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_arith #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  hsv2rgb_pkg::stage_en_t      en_i,
  input  logic [FRAC_BITS:0]          s_i,
  input  logic [FRAC_BITS:0]          v_i,
  input  logic [hsv2rgb_pkg::K_W-1:0] k_i,
  input  hsv2rgb_pkg::sextant_e       sext_i,
  output logic [2*FRAC_BITS+5:0]      sum_o,
  output logic [2*FRAC_BITS:0]        m_o,
  output logic [FRAC_BITS:0]          v_o,
  output hsv2rgb_pkg::sextant_e       sext_o
);
  import hsv2rgb_pkg::*;

  localparam int VW    = FRAC_BITS + 1;
  localparam int CW    = 2 * FRAC_BITS + 1;  // c and m, up to 1.0 with 2F fraction bits
  localparam int SUM_W = 2 * FRAC_BITS + 6;  // up to 60.0

  // stage 2
  logic [2*VW-1:0] c_full;
  logic [CW-1:0]   c_q;
  logic [VW-1:0]   v2_q;
  logic [K_W-1:0]  k2_q;
  sextant_e        sext2_q;

  // stage 3
  logic [CW+K_W-1:0] ck_full;
  logic [CW-1:0]     v_wide, m_d, m3_q;
  logic [SUM_W-1:0]  ck_q;
  logic [VW-1:0]     v3_q;
  sextant_e          sext3_q;

  // stage 4
  logic [SUM_W:0]   m60, sum_full;
  logic [SUM_W-1:0] sum_q;
  logic [CW-1:0]    m4_q;
  logic [VW-1:0]    v4_q;
  sextant_e         sext4_q;

  assign c_full = v_i * s_i;

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      c_q     <= c_full[CW-1:0];
      v2_q    <= v_i;
      k2_q    <= k_i;
      sext2_q <= sext_i;
    end
  end

  always_comb begin
    v_wide  = {v2_q, {FRAC_BITS{1'b0}}};
    m_d     = v_wide - c_q;
    ck_full = c_q * k2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sub) begin
      ck_q    <= ck_full[SUM_W-1:0];
      m3_q    <= m_d;
      v3_q    <= v2_q;
      sext3_q <= sext2_q;
    end
  end

  always_comb begin
    m60      = ((SUM_W + 1)'(m3_q) << 6) - ((SUM_W + 1)'(m3_q) << 2);
    sum_full = (SUM_W + 1)'(ck_q) + m60;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sum_q   <= sum_full[SUM_W-1:0];
      m4_q    <= m3_q;
      v4_q    <= v3_q;
      sext4_q <= sext3_q;
    end
  end

  assign sum_o  = sum_q;
  assign m_o    = m4_q;
  assign v_o    = v4_q;
  assign sext_o = sext4_q;

endmodule

### rtl/hsv2rgb_chan.sv
// Stages five to seven: scale to 8-bit channels, divide the secondary by 60,
// then route channels by sextant into the output register. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_chan #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  hsv2rgb_pkg::stage_en_t       en_i,
  input  logic [2*FRAC_BITS+5:0]       sum_i,
  input  logic [2*FRAC_BITS:0]         m_i,
  input  logic [FRAC_BITS:0]           v_i,
  input  hsv2rgb_pkg::sextant_e        sext_i,
  output logic [hsv2rgb_pkg::CH_W-1:0] red_o,
  output logic [hsv2rgb_pkg::CH_W-1:0] green_o,
  output logic [hsv2rgb_pkg::CH_W-1:0] blue_o
);
  import hsv2rgb_pkg::*;

  localparam int VW    = FRAC_BITS + 1;
  localparam int CW    = 2 * FRAC_BITS + 1;
  localparam int SUM_W = 2 * FRAC_BITS + 6;

  // stage 5: times 255, drop the fraction bits
  logic [SUM_W+7:0] sum255;
  logic [CW+7:0]    m255;
  logic [VW+7:0]    v255;
  logic [T_W-1:0]   t_val;
  logic [U_W-1:0]   u_q;
  logic [Q_W-1:0]   cm5_q, mm5_q;
  sextant_e         sext5_q;

  // stage 6: reciprocal estimate of u / 15
  logic [U_W+RCP_W-1:0] qe_full;
  logic [U_W-1:0]       u6_q;
  logic [Q_W-1:0]       qe_q, cm6_q, mm6_q;
  sextant_e             sext6_q;

  // stage 7: correction and routing
  logic [U_W:0]      q15, rem;
  logic [Q_W-1:0]    xq;
  logic [CH_W-1:0]   cm, xm, mm;
  logic [CH_W-1:0]   red_d, green_d, blue_d, red_q, green_q, blue_q;

  always_comb begin
    sum255 = ((SUM_W + 8)'(sum_i) << 8) - (SUM_W + 8)'(sum_i);
    m255   = ((CW + 8)'(m_i) << 8) - (CW + 8)'(m_i);
    v255   = ((VW + 8)'(v_i) << 8) - (VW + 8)'(v_i);
    t_val  = sum255[2*FRAC_BITS+T_W-1:2*FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.scale) begin
      u_q     <= t_val[T_W-1:2];
      cm5_q   <= v255[FRAC_BITS+Q_W-1:FRAC_BITS];
      mm5_q   <= m255[2*FRAC_BITS+Q_W-1:2*FRAC_BITS];
      sext5_q <= sext_i;
    end
  end

  assign qe_full = u_q * DIV15_RCP;

  always_ff @(posedge clk_i) begin
    if (en_i.recip) begin
      u6_q    <= u_q;
      qe_q    <= qe_full[DIV15_SHIFT+Q_W-1:DIV15_SHIFT];
      cm6_q   <= cm5_q;
      mm6_q   <= mm5_q;
      sext6_q <= sext5_q;
    end
  end

  always_comb begin
    // estimate is at most one low
    q15 = ((U_W + 1)'(qe_q) << 4) - (U_W + 1)'(qe_q);
    rem = (U_W + 1)'(u6_q) - q15;
    xq  = (rem >= DIV15_N) ? qe_q + Q_W'(1) : qe_q;
    cm  = sat_chan(cm6_q);
    xm  = sat_chan(xq);
    mm  = sat_chan(mm6_q);

    case (sext6_q)
      SEXT_0: begin
        red_d = cm; green_d = xm; blue_d = mm;
      end
      SEXT_1: begin
        red_d = xm; green_d = cm; blue_d = mm;
      end
      SEXT_2: begin
        red_d = mm; green_d = cm; blue_d = xm;
      end
      SEXT_3: begin
        red_d = mm; green_d = xm; blue_d = cm;
      end
      SEXT_4: begin
        red_d = xm; green_d = mm; blue_d = cm;
      end
      default: begin
        red_d = cm; green_d = mm; blue_d = xm;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.out) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

### rtl/hsv_to_rgb_core.sv
// HSV to RGB converter, seven-stage pipeline with valid/ready on both sides.
// Throughput: one beat per cycle while the output is not stalled; each stage holds its item
// when the next is full, so bubbles close up and a stalled output still lets upstream stages fill.
// Reset clears only the per-stage valid bits; the datapath registers are not reset.
// Depends on hsv2rgb_pkg, hsv2rgb_hue, hsv2rgb_arith and hsv2rgb_chan.
`timescale 1ns / 1ps

module hsv_to_rgb_core #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_i,
  input  logic [hsv2rgb_pkg::SV_W-1:0]  saturation_i,
  input  logic [hsv2rgb_pkg::SV_W-1:0]  brightness_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hsv2rgb_pkg::CH_W-1:0]  red_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]  green_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]  blue_o
);
  import hsv2rgb_pkg::*;

  localparam int NSTG = 7;

  logic [NSTG-1:0] vld_d, vld_q, en;
  logic [NSTG:0]   rdy;
  stage_en_t       stg_en;

  logic [FRAC_BITS:0]     s1, v1, v4;
  logic [K_W-1:0]         k1;
  sextant_e               sext1, sext4;
  logic [2*FRAC_BITS+5:0] sum4;
  logic [2*FRAC_BITS:0]   m4;

  // A stage loads when it is empty or its contents move on this cycle
  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i]  = !vld_q[i] || rdy[i+1];
      rdy[i] = en[i];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
    stg_en = stage_en_t'(en[0:0] == 1'b1 ? {en[0], en[1], en[2], en[3], en[4], en[5], en[6]}
                                         : {en[0], en[1], en[2], en[3], en[4], en[5], en[6]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NSTG-1];

  hsv2rgb_hue #(
    .FRAC_BITS(FRAC_BITS)
  ) u_hue (
    .clk_i       (clk_i),
    .en_i        (stg_en),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .brightness_i(brightness_i),
    .s_o         (s1),
    .v_o         (v1),
    .k_o         (k1),
    .sext_o      (sext1)
  );

  hsv2rgb_arith #(
    .FRAC_BITS(FRAC_BITS)
  ) u_arith (
    .clk_i (clk_i),
    .en_i  (stg_en),
    .s_i   (s1),
    .v_i   (v1),
    .k_i   (k1),
    .sext_i(sext1),
    .sum_o (sum4),
    .m_o   (m4),
    .v_o   (v4),
    .sext_o(sext4)
  );

  hsv2rgb_chan #(
    .FRAC_BITS(FRAC_BITS)
  ) u_chan (
    .clk_i  (clk_i),
    .en_i   (stg_en),
    .sum_i  (sum4),
    .m_i    (m4),
    .v_i    (v4),
    .sext_i (sext4),
    .red_o  (red_o),
    .green_o(green_o),
    .blue_o (blue_o)
  );

endmodule

### rtl/hsv2rgb_chk.sv
// Port-level checks for hsv_to_rgb_core, attached by the bind below.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [hsv2rgb_pkg::HUE_W-1:0] hue_i,
  input logic [hsv2rgb_pkg::SV_W-1:0]  saturation_i,
  input logic [hsv2rgb_pkg::SV_W-1:0]  brightness_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [hsv2rgb_pkg::CH_W-1:0]  red_o,
  input logic [hsv2rgb_pkg::CH_W-1:0]  green_o,
  input logic [hsv2rgb_pkg::CH_W-1:0]  blue_o
);

  // output beat held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before the beat was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled output beat changed");

  // with nothing waiting at the output, every stage has room
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output is empty");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind hsv_to_rgb_core hsv2rgb_chk u_hsv2rgb_chk (.*);
